@@ src/urh_pkg.sv @@
// Shared types and constants for the undo/redo history ring.
`timescale 1ns / 1ps

package urh_pkg;

    localparam int OUT_SNAP_W = 48;
    localparam int SLOT_W     = 5;
    localparam int ACT_W      = 2;
    localparam int INTERVAL_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = 8'd2;

    // register index (paddr[2])
    localparam logic REG_CHECK_INTERVAL = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_UNDO = 2'd1,
        ACT_REDO = 2'd2
    } t_action;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [OUT_SNAP_W-1:0] live_snapshot;
    } t_item;

    typedef struct packed {
        logic [OUT_SNAP_W-1:0] cursor_snapshot;
        logic                  cursor_moved;
        logic                  snapshot_recorded;
        logic [SLOT_W-1:0]     cursor_slot;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FETCH,
        S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch a new item
        logic rd;        // read the slot at the cursor
        logic eval;      // apply the item to the pointers and the ring
    } t_dp_cmd;

endpackage

@@ src/urh_ctrl.sv @@
// Sequencing state machine for the undo/redo history ring.
`timescale 1ns / 1ps

module urh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_done,
    output urh_pkg::t_dp_cmd o_cmd
);
    import urh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // result goes out now; a new item may be taken in the same cycle
                o_busy = 1'b0;
                o_done = 1'b1;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> $past(o_cmd.rd))
        else $error("evaluation without a preceding slot read");
    a_done_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_cmd.rd) && $past(o_cmd.eval, 2))
        else $error("result strobe out of sequence");
`endif

endmodule

@@ src/urh_dp.sv @@
// Datapath for the undo/redo history ring: snapshot memory, pointers, tick counter.
`timescale 1ns / 1ps

module urh_dp #(
    parameter int HISTORY_DEPTH = 32,
    parameter int SNAP_WIDTH    = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  urh_pkg::t_dp_cmd                     i_cmd,
    input  urh_pkg::t_item                       i_item,
    input  logic [urh_pkg::INTERVAL_W-1:0]       i_interval,
    output urh_pkg::t_result                     o_result
);
    import urh_pkg::*;

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(HISTORY_DEPTH - 1);

    logic [SNAP_WIDTH-1:0] mem [HISTORY_DEPTH];

    logic [ACT_W-1:0]      r_action;
    logic [SNAP_WIDTH-1:0] r_live;
    logic [SNAP_WIDTH-1:0] r_rd_data;
    logic                  r_rd_zero;
    logic                  r_slot0_vld;
    logic [PW-1:0]         r_cur, n_cur;
    logic [PW-1:0]         r_old, n_old;
    logic [PW-1:0]         r_new, n_new;
    logic [INTERVAL_W-1:0] r_tick, n_tick;
    logic                  r_moved, n_moved;
    logic                  r_rec, n_rec;

    logic [63:0]           w_live_ext;
    logic [63:0]           w_slot_ext;
    logic [31:0]           w_cur_ext;
    logic [SNAP_WIDTH-1:0] w_slot;
    logic [PW-1:0]         w_nxt;
    logic [PW-1:0]         w_prv;
    logic [PW-1:0]         w_old_nxt;
    logic [INTERVAL_W-1:0] w_tick_inc;
    logic                  w_check;
    logic                  w_we;

    assign w_live_ext = 64'(i_item.live_snapshot);

    // slot zero reads as zero until it is first written
    assign w_slot     = (r_rd_zero && !r_slot0_vld) ? '0 : r_rd_data;
    assign w_nxt      = (r_cur == LAST_POS) ? '0 : r_cur + 1'b1;
    assign w_prv      = (r_cur == '0) ? LAST_POS : r_cur - 1'b1;
    assign w_old_nxt  = (r_old == LAST_POS) ? '0 : r_old + 1'b1;
    assign w_tick_inc = r_tick + 1'b1;
    assign w_check    = (w_tick_inc >= i_interval);

    always_comb begin
        n_cur   = r_cur;
        n_old   = r_old;
        n_new   = r_new;
        n_tick  = r_tick;
        n_moved = r_moved;
        n_rec   = r_rec;
        w_we    = 1'b0;
        if (i_cmd.capture) begin
            n_moved = 1'b0;
            n_rec   = 1'b0;
        end else if (i_cmd.eval) begin
            case (r_action)
                ACT_TICK: begin
                    n_tick = w_check ? '0 : w_tick_inc;
                    if (w_check && (w_slot != r_live)) begin
                        n_cur = w_nxt;
                        n_new = w_nxt;
                        n_rec = 1'b1;
                        w_we  = 1'b1;
                        if (w_nxt == r_old) begin
                            n_old = w_old_nxt;
                        end
                    end
                end
                ACT_UNDO: begin
                    if (r_cur != r_old) begin
                        n_cur   = w_prv;
                        n_moved = 1'b1;
                    end
                end
                ACT_REDO: begin
                    if ((r_cur != r_new) && (w_nxt != r_old)) begin
                        n_cur   = w_nxt;
                        n_moved = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_old       <= '0;
            r_new       <= '0;
            r_tick      <= '0;
            r_moved     <= 1'b0;
            r_rec       <= 1'b0;
            r_slot0_vld <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_old   <= n_old;
            r_new   <= n_new;
            r_tick  <= n_tick;
            r_moved <= n_moved;
            r_rec   <= n_rec;
            if (w_we && (w_nxt == '0)) begin
                r_slot0_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_item.action;
            r_live   <= w_live_ext[SNAP_WIDTH-1:0];
        end
    end

    // snapshot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_nxt] <= r_live;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_cur];
            r_rd_zero <= (r_cur == '0);
        end
    end

    assign w_slot_ext = 64'(w_slot);
    assign w_cur_ext  = 32'(r_cur);

    assign o_result.cursor_snapshot   = w_slot_ext[OUT_SNAP_W-1:0];
    assign o_result.cursor_moved      = r_moved;
    assign o_result.snapshot_recorded = r_rec;
    assign o_result.cursor_slot       = w_cur_ext[SLOT_W-1:0];

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur) < HISTORY_DEPTH) && (32'(r_old) < HISTORY_DEPTH)
        && (32'(r_new) < HISTORY_DEPTH))
        else $error("ring pointer beyond depth");
    a_moved_rec_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_moved && r_rec))
        else $error("cursor move and record flagged for one item");
    a_rec_sets_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_new == r_cur) && (r_cur != r_old))
        else $error("recorded slot is not newest or collides with oldest");
`endif

endmodule

@@ src/undo_redo_history_ring.sv @@
// Top level of the undo/redo history ring: APB register, controller, datapath.
`timescale 1ns / 1ps

// Channel   Direction  Transfer when                        Payload
// item      in         start && !busy at a rising edge      i_item (t_item)
// result    out        o_done high (one cycle, no stall)    o_result (t_result)
// config    in         psel && penable && pwrite && pready  pwdata[7:0] at paddr 0
//
// For each item after its transfer, the cursor slot is read, the item is
// applied, the slot at the new cursor is read back, and the result is
// shown; both reads use the registered read port of the snapshot memory.
// A new item is taken in the cycle its predecessor's result shows.
// Reset is synchronous active low; pointers, tick counter and check_interval
// (2) reset, slot zero reads as zero until written, no clearing pass.
// The receiver cannot stall: o_done is a one-cycle strobe.
module undo_redo_history_ring #(
    parameter int HISTORY_DEPTH = 32,
    parameter int SNAP_WIDTH    = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           start,
    output logic                           busy,
    input  urh_pkg::t_item                 i_item,
    // result channel
    output logic                           o_done,
    output urh_pkg::t_result               o_result,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [urh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [urh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [urh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import urh_pkg::*;

    logic [INTERVAL_W-1:0] r_check_interval;
    logic                  w_cfg_wr;
    t_dp_cmd               w_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register index is paddr[2]; only check_interval exists
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_interval <= CHECK_INTERVAL_RST;
        end else if (w_cfg_wr && (paddr[2] == REG_CHECK_INTERVAL)) begin
            r_check_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CHECK_INTERVAL) ?
                    APB_DATA_W'(r_check_interval) : '0;

    urh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    urh_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SNAP_WIDTH    (SNAP_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_item),
        .i_interval (r_check_interval),
        .o_result   (o_result)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item transfer did not make the block busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("result not delivered four cycles after transfer");
`endif

endmodule

@@ tb/tb_undo_redo_history_ring.sv @@
// Self-checking testbench for the undo/redo history ring: directed and random items, APB setup.
`timescale 1ns / 1ps

module tb_undo_redo_history_ring;
    import urh_pkg::*;

    localparam int DEPTH  = 32;
    localparam int SNAP_W = OUT_SNAP_W;

    // action code 3 has no meaning; the block must leave its state alone
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    // register 0 lives at byte address 0
    localparam logic [APB_ADDR_W-1:0] ADDR_CHECK_INTERVAL = {REG_CHECK_INTERVAL, 2'b00};

    localparam int RAND_ITEMS   = 1030;
    localparam int BLOCKS       = 16;     // random part: 4 phases x 4 interval settings
    localparam int STALL_LIMIT  = 5000;   // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 8;      // idle margin after the final drain

    // ------------------------------------------------------------------
    // Predictor: mirrors the ring, pointers, tick counter and interval,
    // and holds the expected result of every accepted item in order.
    // ------------------------------------------------------------------
    class history_scoreboard;
        logic [SNAP_W-1:0]     slots [DEPTH];
        logic [SLOT_W-1:0]     cursor;
        logic [SLOT_W-1:0]     oldest;
        logic [SLOT_W-1:0]     newest;
        logic [INTERVAL_W-1:0] ticks;
        logic [INTERVAL_W-1:0] interval;
        t_result               expected_q [$];
        int                    errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            cursor   = '0;
            oldest   = '0;
            newest   = '0;
            ticks    = '0;
            interval = CHECK_INTERVAL_RST;
            errors   = 0;
        endfunction

        function logic [SLOT_W-1:0] ring_next(logic [SLOT_W-1:0] p);
            return (p == DEPTH - 1) ? '0 : p + 1'b1;
        endfunction

        function logic [SLOT_W-1:0] ring_prev(logic [SLOT_W-1:0] p);
            return (p == 0) ? SLOT_W'(DEPTH - 1) : p - 1'b1;
        endfunction

        function logic [SNAP_W-1:0] cursor_value();
            return slots[cursor];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted item and queue the result it must produce
        function void note_item(t_item it);
            t_result r;
            logic [SLOT_W-1:0] nxt;
            r = '0;
            case (it.action)
                ACT_TICK: begin
                    ticks = ticks + 1'b1;
                    if (ticks >= interval) begin
                        ticks = '0;
                        if (slots[cursor] != it.live_snapshot) begin
                            cursor = ring_next(cursor);
                            if (cursor == oldest)
                                oldest = ring_next(oldest);
                            slots[cursor]       = it.live_snapshot;
                            newest              = cursor;
                            r.snapshot_recorded = 1'b1;
                        end
                    end
                end
                ACT_UNDO: begin
                    if (cursor != oldest) begin
                        cursor         = ring_prev(cursor);
                        r.cursor_moved = 1'b1;
                    end
                end
                ACT_REDO: begin
                    nxt = ring_next(cursor);
                    if (cursor != newest && nxt != oldest) begin
                        cursor         = nxt;
                        r.cursor_moved = 1'b1;
                    end
                end
                default: ;
            endcase
            r.cursor_snapshot = slots[cursor];
            r.cursor_slot     = cursor;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.cursor_snapshot !== want.cursor_snapshot) begin
                $display("%0t: cursor_snapshot expected %h actual %h",
                         $time, want.cursor_snapshot, got.cursor_snapshot);
                errors++;
            end
            if (got.cursor_moved !== want.cursor_moved) begin
                $display("%0t: cursor_moved expected %b actual %b",
                         $time, want.cursor_moved, got.cursor_moved);
                errors++;
            end
            if (got.snapshot_recorded !== want.snapshot_recorded) begin
                $display("%0t: snapshot_recorded expected %b actual %b",
                         $time, want.snapshot_recorded, got.snapshot_recorded);
                errors++;
            end
            if (got.cursor_slot !== want.cursor_slot) begin
                $display("%0t: cursor_slot expected %0d actual %0d",
                         $time, want.cursor_slot, got.cursor_slot);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_item                 i_item  = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    history_scoreboard history_sb;
    int                stall_cycles = 0;
    int                cfg_errors   = 0;

    undo_redo_history_ring i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Result monitor and watchdog. Outputs are sampled at the rising edge,
    // before the block's own updates land. The strobe is a one-cycle
    // pulse, so every edge with o_done high is a result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                history_sb.check_result(o_result);
            if ((start && !busy) || o_done || (psel && penable && pready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("undo_redo_history_ring test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item driver. Idle cycles go in front of the item with start low;
    // start is then held until the edge where busy is low. The item is
    // handed to the predictor right at its transfer, so the next item
    // can be built from the up-to-date ring contents.
    // ------------------------------------------------------------------
    task automatic send_item(input t_item it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        history_sb.note_item(it);
    endtask

    task automatic put(input logic [ACT_W-1:0] action, input logic [SNAP_W-1:0] snap);
        t_item it;
        it.action        = action;
        it.live_snapshot = snap;
        send_item(it, 0);
    endtask

    // every item yields one result, so an empty queue means the block is idle
    task automatic drain_items();
        start <= 1'b0;
        while (history_sb.pending() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // check_interval write then read back, only with the block idle.
    // Upper data bits are random; the register keeps the low byte.
    // ------------------------------------------------------------------
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        data                   = $urandom();
        data[INTERVAL_W-1:0]   = value;
        drain_items();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHECK_INTERVAL;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        history_sb.interval = value;
        // read transfer straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[INTERVAL_W-1:0] !== value) begin
            $display("%0t: check_interval read expected %h actual %h",
                     $time, value, prdata[INTERVAL_W-1:0]);
            cfg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random traffic as runs: recording bursts of ticks, undo/redo walks
    // (some long enough to hit the oldest slot), and a little noise with
    // the unused action code.
    // ------------------------------------------------------------------
    task automatic run_random(input int count, input int idle_pct);
        t_item       it;
        logic [63:0] r;
        int          kind;
        int          run_len;
        int          sent;
        sent = 0;
        while (sent < count) begin
            kind    = $urandom_range(99);
            run_len = $urandom_range(12, 1);
            if (kind >= 50 && kind < 90 && $urandom_range(3) == 0)
                run_len = $urandom_range(40, 1);
            if (kind >= 94)
                run_len = $urandom_range(3, 1);
            repeat (run_len) begin
                r                = {$urandom(), $urandom()};
                it.live_snapshot = r[SNAP_W-1:0];
                if (kind < 50) begin
                    it.action = ACT_TICK;
                    case ($urandom_range(9))
                        0: it.live_snapshot = history_sb.cursor_value();
                        1: it.live_snapshot = '0;
                        2: it.live_snapshot = '1;
                        default: ;
                    endcase
                end else if (kind < 72) begin
                    it.action = ACT_UNDO;
                end else if (kind < 94) begin
                    it.action = ACT_REDO;
                end else begin
                    it.action = ACT_NONE;
                    if ($urandom_range(1) == 0)
                        it.action = r[SNAP_W+ACT_W-1:SNAP_W];
                end
                send_item(it, idle_pct);
                if (it.action != ACT_NONE)
                    sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int idle_by_phase [4] = '{0, 78, 0, 32};

    initial begin
        history_sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset interval of 2
        put(ACT_UNDO, '0);              // blocked at oldest
        put(ACT_REDO, '0);              // blocked at newest
        put(ACT_NONE, '1);              // unused code: no change
        put(ACT_TICK, '1);              // count 1, no compare
        put(ACT_TICK, '1);              // compare, records slot 1
        put(ACT_TICK, '1);
        put(ACT_TICK, '1);              // compare, same value, nothing stored
        put(ACT_UNDO, '1);              // back to slot 0
        put(ACT_UNDO, '1);              // blocked
        put(ACT_REDO, '0);              // forward to slot 1
        put(ACT_REDO, '0);              // blocked at newest

        // zero interval compares on every tick
        write_interval(8'd0);
        put(ACT_TICK, '0);
        put(ACT_TICK, '0);
        put(ACT_TICK, 48'h5555_5555_5555);

        // interval lowered while the counter is above it
        write_interval(8'd5);
        put(ACT_TICK, 48'h0000_0000_0001);
        put(ACT_TICK, 48'h8000_0000_0000);
        put(ACT_TICK, 48'h1234_5678_9abc);
        write_interval(8'd2);
        put(ACT_TICK, 48'haaaa_aaaa_aaaa);

        write_interval(8'd255);
        put(ACT_TICK, 48'h7fff_ffff_ffff);

        // recording after an undo drops the redo branch
        write_interval(8'd1);
        put(ACT_UNDO, '0);
        put(ACT_UNDO, '0);
        put(ACT_TICK, 48'hffff_0000_ffff);
        put(ACT_REDO, '0);

        // random: four idling phases, four interval settings each
        for (int ph = 0; ph < 4; ph++) begin
            for (int blk = 0; blk < 4; blk++) begin
                case (blk)
                    0: write_interval(8'd1);
                    1: write_interval(INTERVAL_W'($urandom_range(4, 2)));
                    2: write_interval((ph % 2 == 0) ? 8'd0 : 8'd255);
                    default: write_interval(INTERVAL_W'($urandom_range(255)));
                endcase
                run_random(RAND_ITEMS / BLOCKS, idle_by_phase[ph]);
            end
        end

        drain_items();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (history_sb.errors == 0 && cfg_errors == 0 && history_sb.pending() == 0) begin
            $display("undo_redo_history_ring test passed");
        end else begin
            $display("undo_redo_history_ring test failed");
        end
        $finish;
    end

endmodule
